[sv/isort_pkg.sv]
// shared types and constants of the insertion sorter
`default_nettype none

package isort_pkg;

  // element width of the list
  localparam int unsigned DATA_W = 32;

  // register index of the sort direction
  localparam logic REG_ASCENDING = 1'b0;

  // operation applied to every cell of the chain in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHL,
    CELL_SHR
  } cell_op_e;

  // controller states
  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_e;

  // command broadcast along the chain
  typedef struct packed {
    cell_op_e                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/isort_if.sv]
// stream interfaces for list elements and sorted results
`default_nettype none

interface isort_in_if;
  import isort_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_element;

  modport source (output valid, output value, output last_element, input ready);
  modport sink   (input valid, input value, input last_element, output ready);
endinterface

interface isort_out_if;
  import isort_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflow, output ready);
endinterface

`default_nettype wire

[sv/isort_cell.sv]
// one cell of the sorting chain: holds a value and its valid flag
`default_nettype none

module isort_cell (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire isort_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic signed [isort_pkg::DATA_W-1:0] left_data_i,
  input  wire logic                               left_valid_i,
  input  wire logic                               left_gt_i,
  input  wire logic signed [isort_pkg::DATA_W-1:0] right_data_i,
  input  wire logic                               right_valid_i,
  output logic signed [isort_pkg::DATA_W-1:0]      data_o,
  output logic                                    valid_o,
  output logic                                    gt_o
);
  import isort_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     valid_q, valid_d;

  // an empty cell counts as greater than anything
  assign gt_o = !valid_q || (data_q > ctrl_i.value);

  // next value of the cell
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (left_gt_i) begin
          data_d = left_data_i;
        end else if (gt_o) begin
          data_d = ctrl_i.value;
        end
        valid_d = valid_q | left_valid_i;
      end
      CELL_SHL: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      CELL_SHR: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      default: begin
        data_d  = data_q;
        valid_d = valid_q;
      end
    endcase
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stored value
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[sv/isort_ctrl.sv]
// sequencer: fill phase, burst phase, element count and overflow flag
`default_nettype none

module isort_ctrl #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic                               in_last_i,
  input  wire logic signed [isort_pkg::DATA_W-1:0] in_value_i,
  output logic                                    in_ready_o,
  input  wire logic                               ascending_i,
  input  wire logic                               top_valid_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    out_last_o,
  output logic                                    out_overflow_o,
  output isort_pkg::cell_ctrl_t                   cell_ctrl_o
);
  import isort_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  state_e           st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             full;

  assign full = (cnt_q == CNT_W'(MAX_LEN));

  // state, count and overflow registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_FILL;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  // next state and chain command
  always_comb begin
    st_d              = st_q;
    cnt_d             = cnt_q;
    ovf_d             = ovf_q;
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cell_ctrl_o.op    = CELL_HOLD;
    cell_ctrl_o.value = in_value_i;
    unique case (st_q)
      ST_FILL: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cell_ctrl_o.op = CELL_INSERT;
            cnt_d          = cnt_q + 1'b1;
          end
          if (in_last_i) begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid_o = ascending_i | top_valid_i;
        if (ascending_i) begin
          if (out_ready_i) begin
            cell_ctrl_o.op = CELL_SHL;
          end
        end else if (!top_valid_i || out_ready_i) begin
          // descending: slide the run up to the top cell, then drain it
          cell_ctrl_o.op = CELL_SHR;
        end
        if (out_valid_o && out_ready_i) begin
          cnt_d = cnt_q - 1'b1;
          if (out_last_o) begin
            st_d  = ST_FILL;
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
        st_d = ST_FILL;
      end
    endcase
  end

  assign out_last_o     = (cnt_q == CNT_W'(1));
  assign out_overflow_o = ovf_q;

endmodule

`default_nettype wire

[sv/insertion_sorter_top.sv]
// insertion sorter: chain of compare-and-shift cells with an apb register
//
//   channel    dir   beat contents
//   data_in_i  in    value, last_element
//   data_out_o out   sorted_value, last_result, overflow
//   apb        in    ascending_order at byte address 0
//
// one element is taken per cycle while a list fills; every cell compares
// against the new element and shifts in the same cycle
// after the last element the list drains one result per cycle while the
// receiver is ready, from cell 0, or, largest first, from the top cell after
// the run slides up there; no input is taken in the burst
// a stalled result holds in its cell; reset empties the chain
`default_nettype none

module insertion_sorter_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  isort_in_if.sink         data_in_i,
  isort_out_if.source      data_out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import isort_pkg::*;

  logic                     asc_q;
  cell_ctrl_t               cell_ctrl;
  logic signed [DATA_W-1:0] cell_data  [MAX_LEN];
  logic                     cell_valid [MAX_LEN];
  logic                     cell_gt    [MAX_LEN];

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asc_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ASCENDING)) begin
      asc_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_ASCENDING) ? {31'd0, asc_q} : 32'd0;

  // sequencer
  isort_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (data_in_i.valid),
    .in_last_i     (data_in_i.last_element),
    .in_value_i    (data_in_i.value),
    .in_ready_o    (data_in_i.ready),
    .ascending_i   (asc_q),
    .top_valid_i   (cell_valid[MAX_LEN-1]),
    .out_valid_o   (data_out_o.valid),
    .out_ready_i   (data_out_o.ready),
    .out_last_o    (data_out_o.last_result),
    .out_overflow_o(data_out_o.overflow),
    .cell_ctrl_o   (cell_ctrl)
  );

  // chain of cells, kept in ascending order from cell 0 upward
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data, right_data;
    logic                     left_valid, left_gt, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = cell_ctrl.value;
      assign left_valid = (cell_ctrl.op == CELL_INSERT);
      assign left_gt    = 1'b0;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_last
      assign right_data  = cell_data[i];
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .left_gt_i    (left_gt),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // result beat comes from the end of the chain that drains
  assign data_out_o.sorted_value = asc_q ? cell_data[0] : cell_data[MAX_LEN-1];

endmodule

`default_nettype wire

[test/testbench.sv]
// self-checking testbench of the insertion sorter: directed and random lists, apb order switches
`timescale 1ns / 1ps

module testbench;
  import isort_pkg::*;

  localparam int unsigned LIST_CAP     = 64;
  localparam int unsigned RANDOM_ITEMS = 300;

  // apb byte addresses: the order register and one unmapped slot
  localparam logic [2:0] ADDR_ORDER = {REG_ASCENDING, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflow;
  } sorted_beat_t;

  // tracks the sorted store and the bursts it must release
  class sort_scoreboard;
    logic signed [DATA_W-1:0] store[$];
    sorted_beat_t             expected_beats[$];
    logic                     overflow_seen;
    logic                     ascending;
    int unsigned              cap;
    int unsigned              mismatches;

    function new(int unsigned cap_i);
      cap           = cap_i;
      overflow_seen = 1'b0;
      ascending     = 1'b1;
      mismatches    = 0;
    endfunction

    function void set_order(logic asc);
      ascending = asc;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // insert an accepted element; the last one releases the whole list
    function void note_element(logic signed [DATA_W-1:0] v, logic last_el);
      int unsigned  pos;
      int unsigned  n;
      sorted_beat_t beat;
      if (store.size() >= cap) begin
        overflow_seen = 1'b1;
      end else begin
        pos = store.size();
        while (pos > 0 && store[pos-1] > v) pos--;
        store.insert(pos, v);
      end
      if (last_el) begin
        n = store.size();
        for (int unsigned k = 0; k < n; k++) begin
          beat.sorted_value = ascending ? store[k] : store[n-1-k];
          beat.last_result  = (k == n - 1);
          beat.overflow     = overflow_seen;
          expected_beats.push_back(beat);
        end
        store.delete();
        overflow_seen = 1'b0;
      end
    endfunction

    // compare one result beat with the oldest expected one
    function void check_result(logic signed [DATA_W-1:0] v, logic lr, logic ov);
      sorted_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: sorted_value %0d", v);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      if (v !== want.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", want.sorted_value, v);
        mismatches++;
      end
      if (lr !== want.last_result) begin
        $error("last_result: expected %0b, got %0b", want.last_result, lr);
        mismatches++;
      end
      if (ov !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, ov);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  isort_in_if  in_ch ();
  isort_out_if out_ch ();

  sort_scoreboard sb = new(LIST_CAP);

  logic signed [DATA_W-1:0] list_buf[$];
  int unsigned              elements_sent;
  logic                     quiet_list;

  insertion_sorter_top #(
    .MAX_LEN(LIST_CAP)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_in_i (in_ch),
    .data_out_o(out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = $urandom;
      3, 4:    v = DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // one input beat; entered and left at a falling edge
  task automatic send_element(input logic signed [DATA_W-1:0] v, input logic last_el);
    int unsigned idle;
    idle = quiet_list ? 0 : gap_len();
    if (idle > 0) begin
      in_ch.valid = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_ch.valid        = 1'b1;
    in_ch.value        = v;
    in_ch.last_element = last_el;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    sb.note_element(v, last_el);
    elements_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_list();
    for (int unsigned i = 0; i < list_buf.size(); i++)
      send_element(list_buf[i], i == list_buf.size() - 1);
  endtask

  // let every burst drain and the chain settle before touching the register
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LIST_CAP + 8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_ORDER) sb.set_order(data[0]);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // read back the order register against the predicted setting
  task automatic check_order_reg();
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_ORDER;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== {31'b0, sb.ascending}) begin
      $error("ascending_order: expected %0d, got %0d", sb.ascending, got);
      sb.mismatches++;
    end
  endtask

  task automatic write_order(input logic asc);
    logic [31:0] data;
    data    = $urandom;
    data[0] = asc;
    apb_write(ADDR_ORDER, data);
    check_order_reg();
  endtask

  // result side back-pressure: runs of ready, then stalls
  initial begin : result_ready_gen
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8))
        @(negedge clk_i);
      out_ch.ready = 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2))
        @(negedge clk_i);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.sorted_value, out_ch.last_result, out_ch.overflow);
  end

  // run limit
  initial begin : run_limit
    #5000000;
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned list_no;
    int unsigned len;
    in_ch.valid        = 1'b0;
    in_ch.value        = '0;
    in_ch.last_element = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rst_ni             = 1'b0;
    elements_sent      = 0;
    quiet_list         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset order, single element, extremes, duplicates
    check_order_reg();
    list_buf = '{VAL_MIN};
    send_list();
    list_buf = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN};
    send_list();
    list_buf = '{5, 5, 5, -5, 5};
    send_list();

    // directed: largest first, upper data bits and unmapped address ignored
    wait_idle();
    apb_write(ADDR_ORDER, 32'hFFFF_FFFE);
    apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
    check_order_reg();
    list_buf = '{VAL_MAX, VAL_MIN, 7, 7, -1};
    send_list();
    list_buf = '{-3, -2, -1, 0};
    send_list();
    wait_idle();
    write_order(1'b1);

    // random lists; a few fill or overrun the store
    list_no       = 0;
    elements_sent = 0;
    while (elements_sent < RANDOM_ITEMS) begin
      if (list_no % 4 == 3) begin
        wait_idle();
        write_order($urandom_range(0, 1));
      end
      case (list_no)
        1:       len = LIST_CAP + 1;
        3:       len = LIST_CAP;
        6:       len = LIST_CAP + 5;
        default: len = ($urandom_range(0, 9) == 0) ? $urandom_range(LIST_CAP - 2, LIST_CAP + 6)
                                                   : $urandom_range(1, 12);
      endcase
      quiet_list = ($urandom_range(0, 3) == 0);
      list_buf.delete();
      repeat (len) list_buf.push_back(pick_value());
      send_list();
      list_no++;
    end

    // drain and report
    wait_idle();
    if (sb.mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

[files.f]
sv/isort_pkg.sv
sv/isort_if.sv
sv/isort_cell.sv
sv/isort_ctrl.sv
sv/insertion_sorter_top.sv
test/testbench.sv
